>>> src/simple_8bit_cpu_step_assert.svh
// Assertion macros for the design files; bsm_ctrl uses them.
// The clock is clk and the reset is rst_n in every module that uses them.
`ifndef SIMPLE_8BIT_CPU_STEP_ASSERT_SVH
`define SIMPLE_8BIT_CPU_STEP_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication.
`define BSM_CHECK(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsm check failed");

// Next-cycle implication.
`define BSM_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsm check failed");

`else

`define BSM_CHECK(lbl, ante, cons)
`define BSM_CHECK_NEXT(lbl, ante, cons)

`endif

`endif

>>> src/bsm_pkg.sv
package bsm_pkg;

    // Field widths.
    localparam int OPC_W   = 3;
    localparam int DATA_W  = 8;
    localparam int WORD_W  = 16;
    localparam int FAULT_W = 2;
    localparam int MEM_AW  = 8;
    localparam int MEM_DEPTH = 256;

    // Register file geometry.
    localparam int REG_COUNT = 16;
    localparam int RF_AW     = $clog2(REG_COUNT);

    // Item opcodes.
    localparam logic [OPC_W-1:0] OP_LOAD  = 3'd0;
    localparam logic [OPC_W-1:0] OP_STEP  = 3'd1;
    localparam logic [OPC_W-1:0] OP_RDREG = 3'd2;
    localparam logic [OPC_W-1:0] OP_RDMEM = 3'd3;
    localparam logic [OPC_W-1:0] OP_CLEAR = 3'd4;

    // Instruction codes (high nibble of the first byte).
    localparam logic [3:0] IC_LDM = 4'h1;
    localparam logic [3:0] IC_LDI = 4'h2;
    localparam logic [3:0] IC_STO = 4'h3;
    localparam logic [3:0] IC_MOV = 4'h4;
    localparam logic [3:0] IC_ADD = 4'h5;
    localparam logic [3:0] IC_JEQ = 4'hB;
    localparam logic [3:0] IC_HLT = 4'hC;

    // Fault codes.
    localparam logic [FAULT_W-1:0] FAULT_NONE = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_INSN = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_END  = 2'd2;

    // Last memory address: a step cannot fetch from here.
    localparam logic [MEM_AW-1:0] PC_LAST  = 8'hFF;
    localparam logic [MEM_AW-1:0] PRINT_ADDR = 8'h00;

    typedef struct packed {
        logic [OPC_W-1:0]  opcode;
        logic [WORD_W-1:0] instr_word;
        logic              restart_load;
        logic [DATA_W-1:0] index;
    } cmd_t;

    typedef struct packed {
        logic [MEM_AW-1:0]  pc;
        logic [WORD_W-1:0]  ir;
        logic               halted;
        logic [FAULT_W-1:0] fault;
        logic [DATA_W-1:0]  read_data;
        logic               print_valid;
        logic [DATA_W-1:0]  print_byte;
    } rsp_t;

    // Main memory request from the sequencer.
    typedef struct packed {
        logic              clr;
        logic              rd_en;
        logic [MEM_AW-1:0] rd_addr;
        logic              wr_en;
        logic [MEM_AW-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
    } mem_req_t;

    // Register file request from the sequencer.
    typedef struct packed {
        logic              clr;
        logic              rd_en;
        logic [RF_AW-1:0]  rd_a_addr;
        logic [RF_AW-1:0]  rd_b_addr;
        logic              wr_en;
        logic [RF_AW-1:0]  wr_addr;
        logic [DATA_W-1:0] wr_data;
    } rf_req_t;

endpackage

>>> src/bsm_cmd_if.sv
interface bsm_cmd_if;
    import bsm_pkg::*;

    logic              valid;
    logic              ready;
    logic [OPC_W-1:0]  opcode;
    logic [WORD_W-1:0] instr_word;
    logic              restart_load;
    logic [DATA_W-1:0] index;

    modport source (
        output valid, opcode, instr_word, restart_load, index,
        input  ready
    );

    modport sink (
        input  valid, opcode, instr_word, restart_load, index,
        output ready
    );
endinterface

>>> src/bsm_rsp_if.sv
interface bsm_rsp_if;
    import bsm_pkg::*;

    logic               valid;
    logic               ready;
    logic [MEM_AW-1:0]  pc;
    logic [WORD_W-1:0]  ir;
    logic               halted;
    logic [FAULT_W-1:0] fault;
    logic [DATA_W-1:0]  read_data;
    logic               print_valid;
    logic [DATA_W-1:0]  print_byte;

    modport source (
        output valid, pc, ir, halted, fault, read_data, print_valid, print_byte,
        input  ready
    );

    modport sink (
        input  valid, pc, ir, halted, fault, read_data, print_valid, print_byte,
        output ready
    );
endinterface

>>> src/simple_8bit_cpu_step.sv
// Channel  Role    Words carried
// cmd      sink    opcode, instr_word, restart_load, index
// rsp      source  pc, ir, halted, fault, read_data, print_valid, print_byte
//
// A step reads the two instruction bytes, then the operands, then executes; the
// bytes and the LDM operand use the single read port of the main memory.
// Load word, register read and memory read end in S_LDW, S_RDR and S_RDM;
// clear, unused opcodes and a step at PC_LAST end in S_IDLE. One word is held at the
// input while the previous one runs, and it is refilled in the cycle it is taken.
// After reset the machine is all zero at once: memory and registers carry
// written flags, so there is no clearing pass. A stalled rsp holds the last
// result and the sequencer waits in its final cycle until the register frees.
module simple_8bit_cpu_step (
    input  logic      clk,
    input  logic      rst_n,
    bsm_cmd_if.sink   cmd,
    bsm_rsp_if.source rsp
);
    import bsm_pkg::*;

    logic              pend_valid_reg;
    cmd_t              pend_reg;
    logic              out_valid_reg;
    rsp_t              out_reg;
    logic              out_free;
    logic              take;
    logic              done;
    rsp_t              result;
    mem_req_t          mem_req;
    rf_req_t           rf_req;
    logic [DATA_W-1:0] mem_rdata;
    logic [DATA_W-1:0] rf_rdata_a;
    logic [DATA_W-1:0] rf_rdata_b;

    // Input holding register; it takes a new word as the sequencer takes the old one.
    assign cmd.ready = !pend_valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.valid && cmd.ready)
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            pend_reg <= '{
                opcode:       cmd.opcode,
                instr_word:   cmd.instr_word,
                restart_load: cmd.restart_load,
                index:        cmd.index
            };
        end
    end

    // Output register.
    assign out_free = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_reg <= result;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.pc          = out_reg.pc;
    assign rsp.ir          = out_reg.ir;
    assign rsp.halted      = out_reg.halted;
    assign rsp.fault       = out_reg.fault;
    assign rsp.read_data   = out_reg.read_data;
    assign rsp.print_valid = out_reg.print_valid;
    assign rsp.print_byte  = out_reg.print_byte;

    bsm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (pend_valid_reg),
        .item       (pend_reg),
        .out_free   (out_free),
        .mem_rdata  (mem_rdata),
        .rf_rdata_a (rf_rdata_a),
        .rf_rdata_b (rf_rdata_b),
        .take       (take),
        .done       (done),
        .result     (result),
        .mem_req    (mem_req),
        .rf_req     (rf_req)
    );

    bsm_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (mem_rdata)
    );

    bsm_rf u_rf (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rf_req),
        .rd_a  (rf_rdata_a),
        .rd_b  (rf_rdata_b)
    );
endmodule

>>> src/bsm_mem.sv
module bsm_mem (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bsm_pkg::mem_req_t         req,
    output logic [bsm_pkg::DATA_W-1:0] rd_data
);
    import bsm_pkg::*;

    logic [DATA_W-1:0]    mem_q [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] vld_reg;
    logic [DATA_W-1:0]    rd_data_reg;
    logic                 rd_vld_reg;

    // Storage array: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem_q[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem_q[req.rd_addr];
        end
    end

    // Written flags; an entry never written since a clear reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.clr)
            begin
                vld_reg <= '0;
            end
            else if (req.wr_en)
            begin
                vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_vld_reg <= vld_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;
endmodule

>>> src/bsm_rf.sv
module bsm_rf (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bsm_pkg::rf_req_t           req,
    output logic [bsm_pkg::DATA_W-1:0] rd_a,
    output logic [bsm_pkg::DATA_W-1:0] rd_b
);
    import bsm_pkg::*;

    logic [DATA_W-1:0]    rf_q [REG_COUNT];
    logic [REG_COUNT-1:0] vld_reg;
    logic [DATA_W-1:0]    rd_a_reg;
    logic [DATA_W-1:0]    rd_b_reg;
    logic                 rd_a_vld_reg;
    logic                 rd_b_vld_reg;

    // Register storage: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            rf_q[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_a_reg <= rf_q[req.rd_a_addr];
            rd_b_reg <= rf_q[req.rd_b_addr];
        end
    end

    // Written flags, so that a clear needs no pass over the registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            rd_a_vld_reg <= 1'b0;
            rd_b_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.clr)
            begin
                vld_reg <= '0;
            end
            else if (req.wr_en)
            begin
                vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_a_vld_reg <= vld_reg[req.rd_a_addr];
                rd_b_vld_reg <= vld_reg[req.rd_b_addr];
            end
        end
    end

    assign rd_a = rd_a_vld_reg ? rd_a_reg : '0;
    assign rd_b = rd_b_vld_reg ? rd_b_reg : '0;
endmodule

>>> src/bsm_ctrl.sv
`include "simple_8bit_cpu_step_assert.svh"

module bsm_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    input  bsm_pkg::cmd_t              item,
    input  logic                       out_free,
    input  logic [bsm_pkg::DATA_W-1:0] mem_rdata,
    input  logic [bsm_pkg::DATA_W-1:0] rf_rdata_a,
    input  logic [bsm_pkg::DATA_W-1:0] rf_rdata_b,
    output logic                       take,
    output logic                       done,
    output bsm_pkg::rsp_t              result,
    output bsm_pkg::mem_req_t          mem_req,
    output bsm_pkg::rf_req_t           rf_req
);
    import bsm_pkg::*;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LDW  = 3'd1;
    localparam logic [2:0] S_FB2  = 3'd2;
    localparam logic [2:0] S_DEC  = 3'd3;
    localparam logic [2:0] S_EXE  = 3'd4;
    localparam logic [2:0] S_RDR  = 3'd5;
    localparam logic [2:0] S_RDM  = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic [MEM_AW-1:0]  pc_reg, pc_next;
    logic [MEM_AW-1:0]  lp_reg, lp_next;
    logic [WORD_W-1:0]  ir_reg, ir_next;
    logic [DATA_W-1:0]  b1_reg, b1_next;
    logic [DATA_W-1:0]  lo_reg, lo_next;

    logic               halted;
    logic [FAULT_W-1:0] fault;
    logic [DATA_W-1:0]  read_data;
    logic               print_valid;
    logic [DATA_W-1:0]  print_byte;

    logic [MEM_AW-1:0]  pc_inc;
    logic [MEM_AW-1:0]  ld_base;
    logic [3:0]         dec_code;
    logic [3:0]         exe_code;
    logic [RF_AW-1:0]   exe_r;
    logic [RF_AW-1:0]   exe_t;
    logic [DATA_W-1:0]  exe_b2;

    assign pc_inc   = pc_reg + MEM_AW'(2);
    assign ld_base  = item.restart_load ? '0 : lp_reg;
    assign dec_code = b1_reg[7:4];
    assign exe_code = ir_reg[15:12];
    assign exe_r    = ir_reg[11:8];
    assign exe_t    = ir_reg[3:0];
    assign exe_b2   = ir_reg[7:0];

    // Next-state and datapath control.
    always_comb
    begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        lp_next     = lp_reg;
        ir_next     = ir_reg;
        b1_next     = b1_reg;
        lo_next     = lo_reg;
        take        = 1'b0;
        done        = 1'b0;
        mem_req     = '0;
        rf_req      = '0;
        halted      = 1'b0;
        fault       = FAULT_NONE;
        read_data   = '0;
        print_valid = 1'b0;
        print_byte  = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (item.opcode)
                        OP_LOAD:
                        begin
                            // High byte now, low byte from S_LDW once the output register is free.
                            take            = 1'b1;
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = ld_base;
                            mem_req.wr_data = item.instr_word[15:8];
                            lp_next         = ld_base;
                            lo_next         = item.instr_word[7:0];
                            state_next      = S_LDW;
                        end
                        OP_STEP:
                        begin
                            if (pc_reg == PC_LAST)
                            begin
                                if (out_free)
                                begin
                                    take  = 1'b1;
                                    done  = 1'b1;
                                    fault = FAULT_END;
                                end
                            end
                            else
                            begin
                                take            = 1'b1;
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = pc_reg;
                                state_next      = S_FB2;
                            end
                        end
                        OP_RDREG:
                        begin
                            take             = 1'b1;
                            rf_req.rd_en     = 1'b1;
                            rf_req.rd_a_addr = item.index[RF_AW-1:0];
                            state_next       = S_RDR;
                        end
                        OP_RDMEM:
                        begin
                            take            = 1'b1;
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = item.index;
                            state_next      = S_RDM;
                        end
                        OP_CLEAR:
                        begin
                            if (out_free)
                            begin
                                take        = 1'b1;
                                done        = 1'b1;
                                mem_req.clr = 1'b1;
                                rf_req.clr  = 1'b1;
                                pc_next     = '0;
                                lp_next     = '0;
                                ir_next     = '0;
                            end
                        end
                        default:
                        begin
                            // Unused opcodes report the current state only.
                            if (out_free)
                            begin
                                take = 1'b1;
                                done = 1'b1;
                            end
                        end
                    endcase
                end
            end

            S_LDW:
            begin
                if (out_free)
                begin
                    done            = 1'b1;
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = lp_reg + MEM_AW'(1);
                    mem_req.wr_data = lo_reg;
                    lp_next         = lp_reg + MEM_AW'(2);
                    state_next      = S_IDLE;
                end
            end

            S_FB2:
            begin
                // First byte arrives; fetch the second.
                b1_next         = mem_rdata;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = pc_inc - MEM_AW'(1);
                state_next      = S_DEC;
            end

            S_DEC:
            begin
                // Second byte arrives; fetch operands.
                ir_next      = {b1_reg, mem_rdata};
                rf_req.rd_en = 1'b1;
                if (dec_code == IC_MOV || dec_code == IC_ADD)
                begin
                    rf_req.rd_a_addr = mem_rdata[7:4];
                end
                else
                begin
                    rf_req.rd_a_addr = b1_reg[3:0];
                end
                if (dec_code == IC_ADD)
                begin
                    rf_req.rd_b_addr = mem_rdata[3:0];
                end
                else
                begin
                    rf_req.rd_b_addr = '0;
                end
                mem_req.rd_en   = (dec_code == IC_LDM);
                mem_req.rd_addr = mem_rdata;
                state_next      = S_EXE;
            end

            S_EXE:
            begin
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                    pc_next    = pc_inc;
                    unique case (exe_code)
                        IC_LDM:
                        begin
                            rf_req.wr_en   = 1'b1;
                            rf_req.wr_addr = exe_r;
                            rf_req.wr_data = mem_rdata;
                        end
                        IC_LDI:
                        begin
                            rf_req.wr_en   = 1'b1;
                            rf_req.wr_addr = exe_r;
                            rf_req.wr_data = exe_b2;
                        end
                        IC_STO:
                        begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = exe_b2;
                            mem_req.wr_data = rf_rdata_a;
                            if (exe_b2 == PRINT_ADDR)
                            begin
                                print_valid = 1'b1;
                                print_byte  = rf_rdata_a;
                            end
                        end
                        IC_MOV:
                        begin
                            rf_req.wr_en   = 1'b1;
                            rf_req.wr_addr = exe_t;
                            rf_req.wr_data = rf_rdata_a;
                        end
                        IC_ADD:
                        begin
                            rf_req.wr_en   = 1'b1;
                            rf_req.wr_addr = exe_r;
                            rf_req.wr_data = rf_rdata_a + rf_rdata_b;
                        end
                        IC_JEQ:
                        begin
                            if (rf_rdata_a == rf_rdata_b)
                            begin
                                pc_next = exe_b2;
                            end
                        end
                        IC_HLT:
                        begin
                            halted  = 1'b1;
                            pc_next = pc_reg;
                        end
                        default:
                        begin
                            fault   = FAULT_INSN;
                            pc_next = pc_reg;
                        end
                    endcase
                end
            end

            S_RDR:
            begin
                if (out_free)
                begin
                    done       = 1'b1;
                    read_data  = rf_rdata_a;
                    state_next = S_IDLE;
                end
            end

            S_RDM:
            begin
                if (out_free)
                begin
                    done       = 1'b1;
                    read_data  = mem_rdata;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result word as it stands after this item.
    assign result = '{
        pc:          pc_next,
        ir:          ir_next,
        halted:      halted,
        fault:       fault,
        read_data:   read_data,
        print_valid: print_valid,
        print_byte:  print_byte
    };

    // Architectural and sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
            lp_reg    <= '0;
            ir_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            lp_reg    <= lp_next;
            ir_reg    <= ir_next;
        end
    end

    // Scratch bytes held between sequencer steps.
    always_ff @(posedge clk)
    begin
        b1_reg <= b1_next;
        lo_reg <= lo_next;
    end

    `BSM_CHECK(a_done_needs_room, done, out_free)
    `BSM_CHECK_NEXT(a_clear_zeroes_state, take && item.opcode == OP_CLEAR, pc_reg == '0 && lp_reg == '0 && ir_reg == '0)
    `BSM_CHECK_NEXT(a_end_fault_holds_pc, take && item.opcode == OP_STEP && pc_reg == PC_LAST, pc_reg == PC_LAST && state_reg == S_IDLE)
    `BSM_CHECK_NEXT(a_decode_to_execute, state_reg == S_DEC, state_reg == S_EXE && ir_reg[15:8] == $past(b1_reg))
endmodule

>>> verif/simple_8bit_cpu_step_tb.sv
`timescale 1ns / 1ps

module simple_8bit_cpu_step_tb;
    import bsm_pkg::*;

    localparam int TOTAL_WORDS  = 1650;
    localparam int LONG_HOLD    = 90;
    localparam int DRAIN_CYCLES = 10;
    localparam logic [OPC_W-1:0] OP_SPARE = 3'd7;

    // Shadow copy of the machine: predicts one result word per command word
    // and compares each returned word against the oldest prediction.
    class cpu_shadow;
        logic [DATA_W-1:0] mem_img [MEM_DEPTH];
        logic [DATA_W-1:0] reg_img [REG_COUNT];
        logic [MEM_AW-1:0] pc_q;
        logic [MEM_AW-1:0] load_ptr;
        logic [WORD_W-1:0] ir_q;
        rsp_t              due_q[$];
        int                mismatches;

        function new();
            mismatches = 0;
            clear_all();
        endfunction

        function void clear_all();
            foreach (mem_img[i]) mem_img[i] = '0;
            foreach (reg_img[i]) reg_img[i] = '0;
            pc_q     = '0;
            load_ptr = '0;
            ir_q     = '0;
        endfunction

        // Work out the result of one accepted command word.
        function void note_word(cmd_t c);
            rsp_t              r;
            logic [MEM_AW-1:0] a1;
            logic [MEM_AW-1:0] nxt;
            logic [DATA_W-1:0] b1;
            logic [DATA_W-1:0] b2;
            logic [3:0]        code;
            logic [3:0]        ra;
            logic [3:0]        rs;
            logic [3:0]        rt;
            r = '0;
            case (c.opcode)
                OP_LOAD:
                begin
                    if (c.restart_load)
                        load_ptr = '0;
                    a1 = load_ptr + 8'd1;
                    mem_img[load_ptr] = c.instr_word[15:8];
                    mem_img[a1]       = c.instr_word[7:0];
                    load_ptr = load_ptr + 8'd2;
                end
                OP_STEP:
                begin
                    if (pc_q == PC_LAST) begin
                        r.fault = FAULT_END;
                    end else begin
                        a1   = pc_q + 8'd1;
                        nxt  = pc_q + 8'd2;
                        b1   = mem_img[pc_q];
                        b2   = mem_img[a1];
                        code = b1[7:4];
                        ra   = b1[3:0];
                        rs   = b2[7:4];
                        rt   = b2[3:0];
                        ir_q = {b1, b2};
                        case (code)
                            IC_LDM:
                            begin
                                reg_img[ra] = mem_img[b2];
                                pc_q = nxt;
                            end
                            IC_LDI:
                            begin
                                reg_img[ra] = b2;
                                pc_q = nxt;
                            end
                            IC_STO:
                            begin
                                mem_img[b2] = reg_img[ra];
                                if (b2 == PRINT_ADDR) begin
                                    r.print_valid = 1'b1;
                                    r.print_byte  = reg_img[ra];
                                end
                                pc_q = nxt;
                            end
                            IC_MOV:
                            begin
                                reg_img[rt] = reg_img[rs];
                                pc_q = nxt;
                            end
                            IC_ADD:
                            begin
                                reg_img[ra] = reg_img[rs] + reg_img[rt];
                                pc_q = nxt;
                            end
                            IC_JEQ:
                            begin
                                pc_q = (reg_img[ra] == reg_img[0]) ? b2 : nxt;
                            end
                            IC_HLT:
                            begin
                                r.halted = 1'b1;
                            end
                            default:
                            begin
                                r.fault = FAULT_INSN;
                            end
                        endcase
                    end
                end
                OP_RDREG:
                begin
                    r.read_data = reg_img[c.index[3:0]];
                end
                OP_RDMEM:
                begin
                    r.read_data = mem_img[c.index];
                end
                OP_CLEAR:
                begin
                    clear_all();
                end
                default:
                begin
                end
            endcase
            r.pc = pc_q;
            r.ir = ir_q;
            due_q.push_back(r);
        endfunction

        function void cmp_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
            end
        endfunction

        // Compare one returned result word with the oldest prediction.
        function void check_word(rsp_t got);
            rsp_t want;
            if (due_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, got);
                return;
            end
            want = due_q.pop_front();
            cmp_field("pc",          want.pc,          got.pc);
            cmp_field("ir",          want.ir,          got.ir);
            cmp_field("halted",      want.halted,      got.halted);
            cmp_field("fault",       want.fault,       got.fault);
            cmp_field("read_data",   want.read_data,   got.read_data);
            cmp_field("print_valid", want.print_valid, got.print_valid);
            cmp_field("print_byte",  want.print_byte,  got.print_byte);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    bsm_cmd_if cmd_bus ();
    bsm_rsp_if rsp_bus ();

    simple_8bit_cpu_step u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    cpu_shadow cpu_ref = new();

    // Shared between the two sides: calm suppresses idling, hold_req asks
    // the receiver for one long hold-off.
    bit calm     = 1'b0;
    bit hold_req = 1'b0;
    int words_sent = 0;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_idle();
        int unsigned roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic cmd_t pack_word(logic [OPC_W-1:0] op, logic [WORD_W-1:0] w,
                                       logic rl, logic [DATA_W-1:0] ix);
        cmd_t c;
        c.opcode       = op;
        c.instr_word   = w;
        c.restart_load = rl;
        c.index        = ix;
        return c;
    endfunction

    // A random instruction, weighted towards the defined ones. Jumps land half the
    // time inside a program of span words, sometimes on the last address.
    function automatic logic [WORD_W-1:0] rand_insn(int unsigned span);
        int unsigned     pick;
        int unsigned     j;
        logic [3:0]      code;
        logic [3:0]      rr;
        logic [7:0]      lo;
        pick = $urandom_range(0, 99);
        rr   = ($urandom_range(0, 3) == 0) ? 4'h0 : 4'($urandom);
        lo   = 8'($urandom);
        if (pick < 20) begin
            code = IC_LDI;
        end else if (pick < 30) begin
            code = IC_LDM;
        end else if (pick < 45) begin
            code = IC_STO;
            if ($urandom_range(0, 2) == 0)
                lo = PRINT_ADDR;
        end else if (pick < 55) begin
            code = IC_MOV;
        end else if (pick < 70) begin
            code = IC_ADD;
        end else if (pick < 84) begin
            code = IC_JEQ;
            j = $urandom_range(0, 9);
            if (j < 5)
                lo = 8'(2 * $urandom_range(0, span - 1));
            else if (j < 7)
                lo = PC_LAST;
        end else if (pick < 91) begin
            code = IC_HLT;
        end else begin
            do
                code = 4'($urandom);
            while (code inside {IC_LDM, IC_LDI, IC_STO, IC_MOV, IC_ADD, IC_JEQ, IC_HLT});
        end
        return {code, rr, lo};
    endfunction

    // Offer one command word and return at the edge where it is taken.
    task automatic offer_word(cmd_t c);
        int gap;
        gap = pick_idle();
        if (gap > 0) begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid        <= 1'b1;
        cmd_bus.opcode       <= c.opcode;
        cmd_bus.instr_word   <= c.instr_word;
        cmd_bus.restart_load <= c.restart_load;
        cmd_bus.index        <= c.index;
        do
            @(posedge clk);
        while (cmd_bus.ready !== 1'b1);
        cpu_ref.note_word(c);
        words_sent++;
    endtask

    task automatic wait_drained();
        cmd_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (cpu_ref.due_q.size() != 0);
    endtask

    task automatic offer_read();
        if ($urandom_range(0, 1) == 0)
            offer_word(pack_word(OP_RDREG, 16'($urandom), 1'($urandom), 8'($urandom)));
        else
            offer_word(pack_word(OP_RDMEM, 16'($urandom), 1'($urandom), 8'($urandom)));
    endtask

    // Load a short program from address 0, usually on a cleared machine,
    // then step through it with the odd read mixed in.
    task automatic run_program();
        int n;
        int steps;
        n = $urandom_range(2, 10);
        if ($urandom_range(0, 9) < 7)
            offer_word(pack_word(OP_CLEAR, 16'($urandom), 1'($urandom), 8'($urandom)));
        for (int k = 0; k < n; k++)
            offer_word(pack_word(OP_LOAD, rand_insn(n), k == 0, 8'($urandom)));
        steps = $urandom_range(3, 25);
        for (int k = 0; k < steps; k++) begin
            if ($urandom_range(0, 6) == 0)
                offer_read();
            else
                offer_word(pack_word(OP_STEP, 16'($urandom), 1'($urandom),
                                     8'($urandom)));
        end
    endtask

    // Long run of loads without restart, so that the load pointer walks
    // through the upper memory and wraps.
    task automatic run_fill();
        int m;
        m = $urandom_range(16, 64);
        for (int k = 0; k < m; k++) begin
            if ($urandom_range(0, 1) == 0)
                offer_word(pack_word(OP_LOAD, rand_insn(64), 1'b0, 8'($urandom)));
            else
                offer_word(pack_word(OP_LOAD, 16'($urandom), 1'b0, 8'($urandom)));
        end
        repeat (4) offer_word(pack_word(OP_RDMEM, 16'($urandom), 1'b0, 8'($urandom)));
        repeat (3) offer_word(pack_word(OP_STEP, 16'($urandom), 1'b0, 8'($urandom)));
    endtask

    // Unstructured words, including the unused opcodes.
    task automatic run_noise();
        int m;
        m = $urandom_range(4, 12);
        repeat (m)
            offer_word(pack_word(3'($urandom), 16'($urandom), 1'($urandom),
                                 8'($urandom)));
    endtask

    // The receiver holds off while the sender keeps offering back to back.
    task automatic run_backlog();
        calm     = 1'b1;
        hold_req = 1'b1;
        repeat (16) begin
            if ($urandom_range(0, 2) == 0)
                offer_read();
            else
                offer_word(pack_word(OP_STEP, 16'($urandom), 1'($urandom),
                                     8'($urandom)));
        end
        calm = 1'b0;
    endtask

    // Result side: check every accepted word and pace ready.
    initial
    begin : rsp_side
        rsp_t got;
        int   stall_left;
        stall_left = 0;
        rsp_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
                got.pc          = rsp_bus.pc;
                got.ir          = rsp_bus.ir;
                got.halted      = rsp_bus.halted;
                got.fault       = rsp_bus.fault;
                got.read_data   = rsp_bus.read_data;
                got.print_valid = rsp_bus.print_valid;
                got.print_byte  = rsp_bus.print_byte;
                cpu_ref.check_word(got);
            end
            if (hold_req) begin
                hold_req = 1'b0;
                rsp_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if (stall_left > 0) begin
                rsp_bus.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_bus.ready <= 1'b1;
                stall_left = pick_idle();
            end
        end
    end

    // Command side: reset, directed words, then random episodes.
    initial
    begin : cmd_side
        int holds_done;
        int pick;
        holds_done = 0;
        rst_n                <= 1'b0;
        cmd_bus.valid        <= 1'b0;
        cmd_bus.opcode       <= OP_LOAD;
        cmd_bus.instr_word   <= '0;
        cmd_bus.restart_load <= 1'b0;
        cmd_bus.index        <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Program using every instruction: load immediates, an add that
        // wraps, a store to the print address, a move, a load from memory,
        // an untaken jump, then a taken jump onto the last address.
        offer_word(pack_word(OP_LOAD, 16'h2A80, 1'b1, 8'h00));
        offer_word(pack_word(OP_LOAD, 16'h2BFF, 1'b0, 8'hFF));
        offer_word(pack_word(OP_LOAD, 16'h5CAB, 1'b0, 8'h00));
        offer_word(pack_word(OP_LOAD, 16'h3C00, 1'b0, 8'hFF));
        offer_word(pack_word(OP_LOAD, 16'h40CD, 1'b0, 8'h00));
        offer_word(pack_word(OP_LOAD, 16'h1E05, 1'b0, 8'hFF));
        offer_word(pack_word(OP_LOAD, 16'hBD10, 1'b0, 8'h00));
        offer_word(pack_word(OP_LOAD, 16'hB0FF, 1'b0, 8'hFF));
        // The last step finds the PC at the end of memory.
        repeat (9) offer_word(pack_word(OP_STEP, 16'hFFFF, 1'b1, 8'hFF));
        offer_word(pack_word(OP_RDREG, 16'h0000, 1'b0, 8'hFC));
        offer_word(pack_word(OP_RDMEM, 16'hFFFF, 1'b1, 8'hFF));
        offer_word(pack_word(OP_SPARE, 16'hFFFF, 1'b1, 8'hFF));
        offer_word(pack_word(OP_CLEAR, 16'h0000, 1'b0, 8'h00));
        // Invalid instruction, then halt over the top of it.
        offer_word(pack_word(OP_LOAD, 16'hF5A5, 1'b1, 8'h00));
        offer_word(pack_word(OP_STEP, 16'h0000, 1'b0, 8'h00));
        offer_word(pack_word(OP_LOAD, 16'hC000, 1'b1, 8'h00));
        offer_word(pack_word(OP_STEP, 16'h0000, 1'b0, 8'h00));
        wait_drained();

        while (words_sent < TOTAL_WORDS) begin
            if ((holds_done == 0 && words_sent > 400) ||
                (holds_done == 1 && words_sent > 1100)) begin
                holds_done++;
                run_backlog();
            end
            if ($urandom_range(0, 99) < 8)
                wait_drained();
            calm = ($urandom_range(0, 99) < 15);
            pick = $urandom_range(0, 99);
            if (pick < 65)
                run_program();
            else if (pick < 80)
                run_fill();
            else
                run_noise();
            calm = 1'b0;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (cpu_ref.mismatches == 0)
            $display("PASS simple_8bit_cpu_step");
        else
            $display("FAIL simple_8bit_cpu_step");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #8000000;
        $display("FAIL simple_8bit_cpu_step");
        $finish;
    end

endmodule
